// ===== rtl/core/bf22_pkg.sv =====
// shared types and constants of the 2x2 box filter
`default_nettype none
package bf22_pkg;

  localparam int PIX_W  = 8;
  localparam int ROW_W  = 12;
  localparam int COL_W  = 11;
  localparam int FW_W   = 12;
  localparam int FH_W   = 13;
  localparam int CFG_W  = 13;
  localparam int CFG_AW = 1;
  localparam int Q_DEPTH = 4;

  localparam logic [FW_W-1:0] FW_RESET = 12'd640;
  localparam logic [FH_W-1:0] FH_RESET = 13'd480;
  localparam logic [FH_W-1:0] MAX_HEIGHT = 13'd4096;

  // register indexes of the config port
  localparam logic [CFG_AW-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_AW-1:0] REG_FRAME_HEIGHT = 1'd1;

  // one classified pixel handed from front to back
  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] filt;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
    logic             has_f;
    logic             has_p1;
    logic             has_p2;
    logic             end_col;
  } bf22_item_t;

endpackage
`default_nettype wire

// ===== rtl/core/bf22_front.sv =====
// front end: config registers, position counters, line store and classification
`default_nettype none
module bf22_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [bf22_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [bf22_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [bf22_pkg::PIX_W-1:0]  in_pixel,
  output logic                             q_push,
  output bf22_pkg::bf22_item_t             q_item,
  input  wire logic                        q_full
);
  import bf22_pkg::*;

  localparam int AW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CMP_W = (AW > FW_W) ? AW : FW_W;

  logic [FW_W-1:0]  fw_r;
  logic [FH_W-1:0]  fh_r;
  logic [AW-1:0]    col_r;
  logic [ROW_W-1:0] row_r;

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [PIX_W-1:0] above_r;

  logic             s2_v_r;
  logic [PIX_W-1:0] s2_px_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;
  logic             s2_end_col_r;
  logic             s2_last_row_r;
  logic [PIX_W-1:0] left_r;
  logic [PIX_W-1:0] ul_r;

  logic [FW_W-1:0]  w_eff;
  logic [FW_W-1:0]  wm1;
  logic [FH_W-1:0]  h_eff;
  logic [FH_W-1:0]  hm1;
  logic             end_col;
  logic             last_row;
  logic             accept;
  logic             fire;
  logic [9:0]       sum;

  // clamp the frame size to the supported range
  always_comb begin
    w_eff = fw_r;
    if (fw_r == '0) begin
      w_eff = FW_W'(1);
    end else if (fw_r > MAX_WIDTH) begin
      w_eff = FW_W'(MAX_WIDTH);
    end
    h_eff = fh_r;
    if (fh_r == '0) begin
      h_eff = FH_W'(1);
    end else if (fh_r > MAX_HEIGHT) begin
      h_eff = MAX_HEIGHT;
    end
    wm1 = w_eff - 1'b1;
    hm1 = h_eff - 1'b1;
  end

  assign end_col  = CMP_W'(col_r) >= CMP_W'(wm1);
  assign last_row = {1'b0, row_r} >= hm1;

  assign fire     = s2_v_r && !q_full;
  assign in_ready = !s2_v_r || fire;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r   <= FW_RESET;
      fh_r   <= FH_RESET;
      col_r  <= '0;
      row_r  <= '0;
      s2_v_r <= 1'b0;
      left_r <= '0;
      ul_r   <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_FRAME_WIDTH:  fw_r <= cfg_wdata[FW_W-1:0];
          REG_FRAME_HEIGHT: fh_r <= cfg_wdata[FH_W-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (end_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
        s2_v_r <= 1'b1;
      end else if (fire) begin
        s2_v_r <= 1'b0;
      end
      if (fire) begin
        left_r <= s2_px_r;
        ul_r   <= above_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s2_px_r       <= in_pixel;
      s2_row_r      <= row_r;
      s2_col_r      <= COL_W'(col_r);
      s2_end_col_r  <= end_col;
      s2_last_row_r <= last_row;
    end
  end

  // line store: old row value is read out as the new one goes in
  always_ff @(posedge clk) begin
    if (accept) begin
      above_r        <= line_mem[col_r];
      line_mem[col_r] <= in_pixel;
    end
  end

  assign sum = 10'(ul_r) + 10'(above_r) + 10'(left_r) + 10'(s2_px_r) + 10'd2;

  always_comb begin
    q_item.px      = s2_px_r;
    q_item.above   = above_r;
    q_item.filt    = sum[9:2];
    q_item.row     = s2_row_r;
    q_item.col     = s2_col_r;
    q_item.has_f   = (s2_row_r != '0) && (s2_col_r != '0);
    q_item.has_p1  = (s2_row_r != '0) && s2_end_col_r;
    q_item.has_p2  = s2_last_row_r;
    q_item.end_col = s2_end_col_r;
  end

  // pixels with no result are dropped here
  assign q_push = fire && (q_item.has_f || q_item.has_p1 || q_item.has_p2);

endmodule
`default_nettype wire

// ===== rtl/core/bf22_queue.sv =====
// short queue of classified pixels between front and back
`default_nettype none
module bf22_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push,
  input  wire bf22_pkg::bf22_item_t  push_item,
  output logic                       full,
  input  wire logic                  pop,
  output bf22_pkg::bf22_item_t       head,
  output logic                       empty
);
  import bf22_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);

  bf22_item_t       mem_r [Q_DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [PW:0]      count_r;

  assign full  = count_r == (PW+1)'(Q_DEPTH);
  assign empty = count_r == '0;
  assign head  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bf22_back.sv =====
// back end: expands each queued pixel into its results, one per cycle unless the output stalls
`default_nettype none
module bf22_back (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire bf22_pkg::bf22_item_t        head,
  input  wire logic                        empty,
  output logic                             pop,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic [bf22_pkg::PIX_W-1:0]       out_value,
  output logic [bf22_pkg::ROW_W-1:0]       out_row,
  output logic [bf22_pkg::COL_W-1:0]       out_column,
  output logic                             out_is_filtered,
  output logic                             out_last_in_run,
  output logic                             out_end_of_frame
);
  import bf22_pkg::*;

  logic [2:0]       done_r, done_nxt;
  logic             ov_r, ov_nxt;
  logic [PIX_W-1:0] val_r, val_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic             filt_r, filt_nxt;
  logic             last_r, last_nxt;
  logic             eof_r, eof_nxt;

  logic [2:0]       pending;
  logic [2:0]       sel;
  logic             load;

  assign pending = {head.has_p2, head.has_p1, head.has_f} & ~done_r;
  assign load    = !empty && (!ov_r || out_ready);

  always_comb begin
    // filtered first, then the pass-through above, then the last-row pixel
    if (pending[0]) begin
      sel = 3'b001;
    end else if (pending[1]) begin
      sel = 3'b010;
    end else begin
      sel = 3'b100;
    end

    done_nxt = done_r;
    ov_nxt   = ov_r && !out_ready;
    val_nxt  = val_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    filt_nxt = filt_r;
    last_nxt = last_r;
    eof_nxt  = eof_r;
    pop      = 1'b0;

    if (load) begin
      ov_nxt   = 1'b1;
      last_nxt = (pending & ~sel) == 3'b000;
      filt_nxt = sel[0];
      eof_nxt  = sel[2] && head.end_col;
      if (sel[0]) begin
        val_nxt = head.filt;
        row_nxt = head.row - 1'b1;
        col_nxt = head.col - 1'b1;
      end else if (sel[1]) begin
        val_nxt = head.above;
        row_nxt = head.row - 1'b1;
        col_nxt = head.col;
      end else begin
        val_nxt = head.px;
        row_nxt = head.row;
        col_nxt = head.col;
      end
      if (last_nxt) begin
        pop      = 1'b1;
        done_nxt = 3'b000;
      end else begin
        done_nxt = done_r | sel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= '0;
      ov_r   <= 1'b0;
    end else begin
      done_r <= done_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r  <= val_nxt;
    row_r  <= row_nxt;
    col_r  <= col_nxt;
    filt_r <= filt_nxt;
    last_r <= last_nxt;
    eof_r  <= eof_nxt;
  end

  assign out_valid        = ov_r;
  assign out_value        = val_r;
  assign out_row          = row_r;
  assign out_column       = col_r;
  assign out_is_filtered  = filt_r;
  assign out_last_in_run  = last_r;
  assign out_end_of_frame = eof_r;

endmodule
`default_nettype wire

// ===== rtl/core/box_filter_2x2_stream_top.sv =====
// top level of the streaming 2x2 box filter
// path: an accepted pixel passes the front stage register, the queue and then the output register
// throughput: one pixel per cycle while each pixel gives at most one result and nothing stalls; the
//   output register moves one result per cycle unless the output stalls, so a pixel with two results
//   (last row or last column) or three (bottom-right) moves its results out one at a time
// reset: synchronous rst_n clears counters, queue and output valid, sets 640 x 480; line store kept
`default_nettype none
module box_filter_2x2_stream_top #(
  parameter int MAX_WIDTH = 2048
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // config write port
  input  wire logic                        cfg_we,
  input  wire logic [bf22_pkg::CFG_AW-1:0] cfg_addr,
  input  wire logic [bf22_pkg::CFG_W-1:0]  cfg_wdata,
  // pixel input
  input  wire logic                        in_tvalid,
  output logic                             in_tready,
  input  wire logic [7:0]                  in_tdata,   // [7:0] pixel
  // result output
  output logic                             out_tvalid,
  input  wire logic                        out_tready,
  output logic [31:0]                      out_tdata,  // [7:0] value, [19:8] row, [30:20] column
  output logic                             out_tlast,  // last result of this input pixel
  output logic [1:0]                       out_tuser   // [0] is_filtered, [1] end_of_frame
);
  import bf22_pkg::*;

  logic             q_push;
  bf22_item_t       q_item;
  logic             q_full;
  logic             q_pop;
  bf22_item_t       q_head;
  logic             q_empty;

  logic [PIX_W-1:0] value;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] column;
  logic             is_filtered;
  logic             end_of_frame;

  // front: counts position, reads the row above, classifies the pixel
  bf22_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_pixel  (in_tdata),
    .q_push    (q_push),
    .q_item    (q_item),
    .q_full    (q_full)
  );

  // queue decouples front stalls from output stalls
  bf22_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_item),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  // back: one result per cycle into the output register unless the output stalls
  bf22_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .empty            (q_empty),
    .pop              (q_pop),
    .out_valid        (out_tvalid),
    .out_ready        (out_tready),
    .out_value        (value),
    .out_row          (row),
    .out_column       (column),
    .out_is_filtered  (is_filtered),
    .out_last_in_run  (out_tlast),
    .out_end_of_frame (end_of_frame)
  );

  assign out_tdata = {1'b0, column, row, value};
  assign out_tuser = {end_of_frame, is_filtered};

  // end of frame comes only on the bottom-right pass-through, which ends its run
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && !out_tuser[0])
    else $error("end of frame on a result that is not last or is filtered");

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue overflow");

  // back only pops a queued entry while loading the output register
  a_pop_loads: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty && (!out_tvalid || out_tready))
    else $error("queue pop without output load");

  // a popped entry ends its run on the result that follows
  a_pop_last: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> out_tvalid && out_tlast)
    else $error("popped entry without a last result");

endmodule
`default_nettype wire
